// ----- sv/cht_pkg.sv -----
// shared constants and types for the cuckoo hash table
`default_nettype none
package cht_pkg;
    localparam int KeyW = 31;
    localparam int CfgW = 5;
    localparam int DefDepth = 16;
    localparam logic [1:0] OpInsert = 2'd0;
    localparam logic [1:0] OpLookup = 2'd1;
    localparam logic [1:0] OpErase = 2'd2;
    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StMiss = 2'd1;
    localparam logic [1:0] StFull = 2'd2;
    localparam logic [1:0] TblNone = 2'd0;
    localparam logic [1:0] TblOne = 2'd1;
    localparam logic [1:0] TblTwo = 2'd2;

    typedef struct packed {
        logic          go;
        logic [KeyW-1:0] dividend;
        logic [CfgW-1:0] divisor;
    } div_req_t;
endpackage
`default_nettype wire

// ----- sv/cht_div.sv -----
// restoring divider, one quotient bit per cycle, key by table size
`default_nettype none
module cht_div
    import cht_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  div_req_t             req,
    output logic                 done,
    output logic [KeyW-1:0]      quot,
    output logic [CfgW-1:0]      rem
);
    localparam int CntW = $clog2(KeyW + 1);
    logic [KeyW-1:0] q_reg, q_next;
    logic [CfgW-1:0] r_reg, r_next;
    logic [CfgW-1:0] d_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next, done_reg, done_next;
    logic [CfgW:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[KeyW-1]};
        if (req.go)
        begin
            q_next = req.dividend;
            r_next = '0;
            cnt_next = CntW'(KeyW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = CfgW'(trial - {1'b0, d_reg});
                q_next = {q_reg[KeyW-2:0], 1'b1};
            end
            else
            begin
                r_next = CfgW'(trial);
                q_next = {q_reg[KeyW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (req.go)
            d_reg <= req.divisor;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem = r_reg;
endmodule
`default_nettype wire

// ----- sv/cht_bank.sv -----
// one key table: synchronous key memory plus valid bits
`default_nettype none
module cht_bank
    import cht_pkg::*;
#(
    parameter int TABLE_DEPTH = DefDepth,
    localparam int IdxW = $clog2(TABLE_DEPTH)
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [IdxW-1:0] rd_addr,
    output logic [KeyW-1:0]      rd_key,
    output logic                 rd_valid,
    input  wire logic            wr_en,
    input  wire logic [IdxW-1:0] wr_addr,
    input  wire logic [KeyW-1:0] wr_key,
    input  wire logic            set_en,
    input  wire logic            clr_en,
    input  wire logic [IdxW-1:0] flag_addr
);
    logic [KeyW-1:0]        mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   rdv_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_key;
        rd_key <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rdv_reg <= 1'b0;
        end
        else
        begin
            rdv_reg <= valid_reg[rd_addr];
            if (set_en)
                valid_reg[flag_addr] <= 1'b1;
            else if (clr_en)
                valid_reg[flag_addr] <= 1'b0;
        end
    end

    assign rd_valid = rdv_reg;
endmodule
`default_nettype wire

// ----- sv/cuckoo_hash_table.sv -----
// top level: two-table cuckoo hash set with eviction sequencer
// lookup and erase: result strobe after states DIV1, DIV2, READ, EVAL; busy drops next cycle
// insert: each placement attempt runs two 31-step hashing divisions, a memory read and the
// update; up to table_size attempts, clamped to 1..TABLE_DEPTH; unknown op: strobe next cycle
// one word at a time; busy stays high through the result strobe
// the result is shown for one cycle on done and cannot be stalled
// reset empties both tables at once and sets table_size to 16
`default_nettype none
module cuckoo_hash_table
    import cht_pkg::*;
#(
    parameter int TABLE_DEPTH = DefDepth,
    localparam int IdxW = $clog2(TABLE_DEPTH)
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [1:0]      op,
    input  wire logic [KeyW-1:0] key,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [CfgW-1:0] cfg_data,
    output logic                 done,
    output logic [1:0]           status,
    output logic [1:0]           found_table,
    output logic [3:0]           found_slot,
    output logic [KeyW-1:0]      dropped_key
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_DIV2 = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [CfgW-1:0] size_reg;
    logic [CfgW-1:0] eff;
    logic [1:0]      op_reg;
    logic [KeyW-1:0] hand_reg, hand_next;
    logic [IdxW-1:0] h1_reg, h2_reg;
    logic            side_reg, side_next;
    logic [CfgW-1:0] n_reg, n_next;
    logic [1:0]      st_reg, st_next, tb_reg, tb_next;
    logic [IdxW-1:0] sl_reg, sl_next;
    logic [KeyW-1:0] dk_reg, dk_next;
    logic            done_reg;
    div_req_t        dreq;
    logic            ddone;
    logic [KeyW-1:0] dquot;
    logic [CfgW-1:0] drem;
    logic [KeyW-1:0] k1, k2;
    logic            v1, v2;
    logic            w1, w2, s1, s2, c1, c2;

    always_comb
    begin
        eff = size_reg;
        if (eff == '0)
            eff = CfgW'(1);
        if ({27'd0, eff} > 32'(TABLE_DEPTH))
            eff = CfgW'(TABLE_DEPTH);
    end

    always_comb
    begin
        dreq.go = 1'b0;
        dreq.dividend = hand_reg;
        dreq.divisor = eff;
        if (state_reg == S_IDLE && start)
        begin
            dreq.go = 1'b1;
            dreq.dividend = key;
        end
        else if (state_reg == S_DIV1 && ddone)
        begin
            dreq.go = 1'b1;
            dreq.dividend = dquot;
        end
        else if (state_reg == S_EVAL && state_next == S_DIV1)
        begin
            dreq.go = 1'b1;
            dreq.dividend = hand_next;
        end
    end

    cht_div u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq),
        .done(ddone), .quot(dquot), .rem(drem)
    );

    cht_bank #(.TABLE_DEPTH(TABLE_DEPTH)) u_one (
        .clk(clk), .rst_n(rst_n), .rd_addr(h1_reg), .rd_key(k1), .rd_valid(v1),
        .wr_en(w1), .wr_addr(h1_reg), .wr_key(hand_reg),
        .set_en(s1), .clr_en(c1), .flag_addr(h1_reg)
    );

    cht_bank #(.TABLE_DEPTH(TABLE_DEPTH)) u_two (
        .clk(clk), .rst_n(rst_n), .rd_addr(h2_reg), .rd_key(k2), .rd_valid(v2),
        .wr_en(w2), .wr_addr(h2_reg), .wr_key(hand_reg),
        .set_en(s2), .clr_en(c2), .flag_addr(h2_reg)
    );

    always_comb
    begin
        state_next = state_reg;
        hand_next = hand_reg;
        side_next = side_reg;
        n_next = n_reg;
        st_next = st_reg;
        tb_next = tb_reg;
        sl_next = sl_reg;
        dk_next = dk_reg;
        w1 = 1'b0; w2 = 1'b0; s1 = 1'b0; s2 = 1'b0; c1 = 1'b0; c2 = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    hand_next = key;
                    side_next = 1'b0;
                    n_next = '0;
                    st_next = StMiss;
                    tb_next = TblNone;
                    sl_next = '0;
                    dk_next = '0;
                    state_next = (op == OpInsert || op == OpLookup || op == OpErase)
                                 ? S_DIV1 : S_DONE;
                end
            end
            S_DIV1:
                if (ddone)
                    state_next = S_DIV2;
            S_DIV2:
                if (ddone)
                    state_next = S_READ;
            S_READ:
                state_next = S_EVAL;
            S_EVAL:
            begin
                state_next = S_DONE;
                if (op_reg == OpInsert)
                begin
                    if (!side_reg)
                    begin
                        w1 = 1'b1;
                        s1 = !v1;
                    end
                    else
                    begin
                        w2 = 1'b1;
                        s2 = !v2;
                    end
                    if ((!side_reg && !v1) || (side_reg && !v2))
                        st_next = StOk;
                    else
                    begin
                        hand_next = side_reg ? k2 : k1;
                        side_next = !side_reg;
                        n_next = n_reg + 1'b1;
                        if (n_reg + 1'b1 >= eff)
                        begin
                            st_next = StFull;
                            dk_next = side_reg ? k2 : k1;
                        end
                        else
                            state_next = S_DIV1;
                    end
                end
                else if (v1 && k1 == hand_reg)
                begin
                    st_next = StOk;
                    tb_next = TblOne;
                    sl_next = h1_reg;
                    c1 = (op_reg == OpErase);
                end
                else if (v2 && k2 == hand_reg)
                begin
                    st_next = StOk;
                    tb_next = TblTwo;
                    sl_next = h2_reg;
                    c2 = (op_reg == OpErase);
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg <= CfgW'(16);
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= (state_next == S_DONE) && (state_reg != S_DONE);
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        hand_reg <= hand_next;
        side_reg <= side_next;
        n_reg <= n_next;
        st_reg <= st_next;
        tb_reg <= tb_next;
        sl_reg <= sl_next;
        dk_reg <= dk_next;
        if (state_reg == S_IDLE && start)
            op_reg <= op;
        if (state_reg == S_DIV1 && ddone)
            h1_reg <= IdxW'(drem);
        if (state_reg == S_DIV2 && ddone)
            h2_reg <= IdxW'(drem);
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign done = done_reg;
    assign status = st_reg;
    assign found_table = tb_reg;
    assign found_slot = 4'(sl_reg);
    assign dropped_key = dk_reg;
endmodule
`default_nettype wire

// ----- sv/cht_checker.sv -----
// port-level assertions for the cuckoo hash table, bound to the top level
`default_nettype none
module cht_checker
    import cht_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire logic            done,
    input wire logic [1:0]      status,
    input wire logic [1:0]      found_table,
    input wire logic [KeyW-1:0] dropped_key
);
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted word did not raise busy");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != StOk |-> found_table == TblNone)
        else $error("table reported without a hit");
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != StFull |-> dropped_key == '0)
        else $error("dropped key set without eviction limit");
endmodule

bind cuckoo_hash_table cht_checker u_cht_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .found_table(found_table), .dropped_key(dropped_key)
);
`default_nettype wire
